>>> design/gbaq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbaq_pkg
// shared types and constants for the gas baseline air quality classifier
// ----------------------------------------------------------------------------
package gbaq_pkg;

    // field widths of the beats
    localparam int CMD_W      = 2;
    localparam int GAS_W      = 24;
    localparam int RATIO_W    = 16;
    localparam int LEVEL_W    = 3;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 2'd1;

    // register reset values
    localparam logic [CFG_W-1:0] WARMUP_RESET = 16'd1800;
    localparam logic [CFG_W-1:0] WEIGHT_RESET = 16'd655;

    // ratio thresholds, q4.12 (0.9, 1.1, 1.5)
    localparam logic [RATIO_W-1:0] RATIO_MAX    = 16'hFFFF;
    localparam logic [RATIO_W-1:0] THR_CLEAN    = 16'd3686;
    localparam logic [RATIO_W-1:0] THR_NORMAL   = 16'd4506;
    localparam logic [RATIO_W-1:0] THR_POLLUTED = 16'd6144;
    localparam int                 RATIO_FRAC   = 12;

    // quality levels
    localparam logic [LEVEL_W-1:0] LVL_WARMUP    = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_CLEAN     = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_NORMAL    = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_POLLUTED  = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_VPOLLUTED = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [GAS_W-1:0] gas_ohms;
    } gbaq_in_t;

    typedef struct packed {
        logic               ready_res;
        logic [RATIO_W-1:0] ratio_q412;
        logic [LEVEL_W-1:0] quality_level;
    } gbaq_out_t;

endpackage

>>> design/gas_baseline_air_quality_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_baseline_air_quality_classifier
// ema gas-resistance baseline with baseline/sample ratio and quality level
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one beat per command (tick, gas sample, restart). ticks,
//   restarts and unused commands complete in the accept cycle and give no
//   result beat. each gas sample gives exactly one m_* result beat.
//   cfg_* channel: register writes (warmup seconds, ema weight), always ready;
//   the user must write them only while the block is idle (not enforced).
// sample processing
//   a gas sample runs one subtract for the step magnitude (two when the
//   sample is below the baseline), a 16-step shift-add multiply by the
//   weight, one update add, a 17-step restoring divide, and a load of the
//   output register. all steps but the load run through the single shared
//   adder, so s_ready is low while a sample is in flight; the next beat is
//   taken once the result has been loaded. a sample during warmup skips
//   the math and goes straight to the output register load.
// reset / stall
//   aresetn (sync, active low) clears the counter, baseline and handshake
//   state and restores the register defaults. a result waits in the output
//   register while m_ready is low; ticks are still accepted meanwhile, but
//   the next sample stalls in its final cycle until the result is taken.
// ----------------------------------------------------------------------------
module gas_baseline_air_quality_classifier
    import gbaq_pkg::*;
#(
    parameter int RESISTANCE_BITS = 24,
    parameter int FRACTION_BITS   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  gbaq_in_t             s_data,

    output logic                 m_valid,
    input  logic                 m_ready,
    output gbaq_out_t            m_data,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // baseline width, shared unit width (product of baseline and weight)
    localparam int BW   = RESISTANCE_BITS + FRACTION_BITS;
    localparam int UW   = BW + CFG_W;
    // alignment of the divide operands to a q4.12 quotient
    localparam int SH_N = (FRACTION_BITS < RATIO_FRAC) ? (RATIO_FRAC - FRACTION_BITS) : 0;
    localparam int SH_D = (FRACTION_BITS > RATIO_FRAC) ? (FRACTION_BITS - RATIO_FRAC) : 0;
    localparam int QW   = RATIO_W + 1;
    localparam int CW   = 5;

    localparam logic [CW-1:0] MUL_FIRST = CW'(CFG_W - 1);
    localparam logic [CW-1:0] DIV_FIRST = CW'(QW - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIFF = 3'd1;
    localparam logic [2:0] ST_NEG  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    // control state
    logic [2:0]                 state_reg, state_next;
    logic [CFG_W-1:0]           sec_reg, sec_next;
    logic                       bvalid_reg, bvalid_next;
    logic [BW-1:0]              base_reg, base_next;
    logic [CFG_W-1:0]           warmup_reg, warmup_next;
    logic [CFG_W-1:0]           weight_reg, weight_next;
    logic                       m_valid_reg, m_valid_next;

    // datapath
    logic [RESISTANCE_BITS-1:0] gas_reg, gas_next;
    logic [UW-1:0]              opa_reg, opa_next;   // product acc / remainder
    logic [UW-1:0]              opb_reg, opb_next;   // step magnitude / divisor
    logic [QW-1:0]              q_reg, q_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       neg_reg, neg_next;
    logic                       ok_reg, ok_next;
    gbaq_out_t                  out_reg, out_next;

    // shared unit
    logic [UW-1:0]              unit_a, unit_b, unit_sum;
    logic                       unit_sub, unit_carry;

    logic [UW-1:0]              sample_ext, base_ext;
    logic [RATIO_W-1:0]         ratio;
    logic [LEVEL_W-1:0]         level;
    gbaq_out_t                  res;

    gbaq_addsub #(
        .WIDTH (UW)
    ) u_addsub (
        .a     (unit_a),
        .b     (unit_b),
        .sub   (unit_sub),
        .sum   (unit_sum),
        .carry (unit_carry)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    assign sample_ext = UW'({gas_reg, {FRACTION_BITS{1'b0}}});
    assign base_ext   = UW'(base_reg);

    // saturation covers ratio >= 16.0 and a zero sample
    always_comb begin
        if (q_reg[QW-1] || (gas_reg == '0)) begin
            ratio = RATIO_MAX;
        end else begin
            ratio = q_reg[RATIO_W-1:0];
        end
        if (ratio < THR_CLEAN) begin
            level = LVL_CLEAN;
        end else if (ratio < THR_NORMAL) begin
            level = LVL_NORMAL;
        end else if (ratio < THR_POLLUTED) begin
            level = LVL_POLLUTED;
        end else begin
            level = LVL_VPOLLUTED;
        end
        if (ok_reg) begin
            res.ready_res     = 1'b1;
            res.ratio_q412    = ratio;
            res.quality_level = level;
        end else begin
            res.ready_res     = 1'b0;
            res.ratio_q412    = '0;
            res.quality_level = LVL_WARMUP;
        end
    end

    always_comb begin
        state_next   = state_reg;
        sec_next     = sec_reg;
        bvalid_next  = bvalid_reg;
        base_next    = base_reg;
        warmup_next  = warmup_reg;
        weight_next  = weight_reg;
        m_valid_next = m_valid_reg;
        gas_next     = gas_reg;
        opa_next     = opa_reg;
        opb_next     = opb_reg;
        q_next       = q_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        ok_next      = ok_reg;
        out_next     = out_reg;
        unit_a       = '0;
        unit_b       = '0;
        unit_sub     = 1'b0;

        // register writes
        if (cfg_valid) begin
            case (cfg_index)
                REG_WARMUP: warmup_next = cfg_data;
                REG_WEIGHT: weight_next = cfg_data;
                default: ;
            endcase
        end

        // result beat taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.cmd)
                        CMD_TICK: begin
                            if (sec_reg != '1) begin
                                sec_next = sec_reg + CFG_W'(1);
                            end
                        end
                        CMD_RESTART: begin
                            sec_next    = '0;
                            bvalid_next = 1'b0;
                            base_next   = '0;
                        end
                        CMD_SAMPLE: begin
                            gas_next = RESISTANCE_BITS'(s_data.gas_ohms);
                            if (bvalid_reg) begin
                                ok_next    = 1'b1;
                                state_next = ST_DIFF;
                            end else if (sec_reg >= warmup_reg) begin
                                // first sample after warmup seeds the baseline
                                base_next   = {RESISTANCE_BITS'(s_data.gas_ohms),
                                               {FRACTION_BITS{1'b0}}};
                                bvalid_next = 1'b1;
                                ok_next     = 1'b1;
                                state_next  = ST_DIFF;
                            end else begin
                                ok_next    = 1'b0;
                                state_next = ST_OUT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIFF: begin
                unit_a   = sample_ext;
                unit_b   = base_ext;
                unit_sub = 1'b1;
                if (unit_carry) begin
                    opb_next   = unit_sum;
                    neg_next   = 1'b0;
                    opa_next   = '0;
                    cnt_next   = MUL_FIRST;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_NEG;
                end
            end
            ST_NEG: begin
                unit_a     = base_ext;
                unit_b     = sample_ext;
                unit_sub   = 1'b1;
                opb_next   = unit_sum;
                neg_next   = 1'b1;
                opa_next   = '0;
                cnt_next   = MUL_FIRST;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                // msb-first shift-add over the weight bits
                unit_a   = opa_reg << 1;
                unit_b   = weight_reg[cnt_reg[3:0]] ? opb_reg : '0;
                opa_next = unit_sum;
                if (cnt_reg == '0) begin
                    state_next = ST_UPD;
                end else begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            ST_UPD: begin
                unit_a     = base_ext;
                unit_b     = opa_reg >> CFG_W;
                unit_sub   = neg_reg;
                base_next  = BW'(unit_sum);
                opa_next   = UW'(BW'(unit_sum)) << SH_N;
                opb_next   = UW'(gas_reg) << (SH_D + RATIO_W);
                q_next     = '0;
                cnt_next   = DIV_FIRST;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // restoring divide, one quotient bit per cycle
                unit_a   = opa_reg;
                unit_b   = opb_reg;
                unit_sub = 1'b1;
                if (unit_carry) begin
                    opa_next = unit_sum;
                end
                q_next   = {q_reg[QW-2:0], unit_carry};
                opb_next = opb_reg >> 1;
                if (cnt_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sec_reg     <= '0;
            bvalid_reg  <= 1'b0;
            base_reg    <= '0;
            warmup_reg  <= WARMUP_RESET;
            weight_reg  <= WEIGHT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sec_reg     <= sec_next;
            bvalid_reg  <= bvalid_next;
            base_reg    <= base_next;
            warmup_reg  <= warmup_next;
            weight_reg  <= weight_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        gas_reg <= gas_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        ok_reg  <= ok_next;
        out_reg <= out_next;
    end

endmodule

>>> design/gbaq_addsub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbaq_addsub
// shared wide adder / subtractor with carry out (no-borrow flag on subtract)
// ----------------------------------------------------------------------------
module gbaq_addsub #(
    parameter int WIDTH = 56
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic             sub,
    output logic [WIDTH-1:0] sum,
    output logic             carry
);

    logic [WIDTH-1:0] b_op;

    assign b_op = sub ? ~b : b;
    assign {carry, sum} = {1'b0, a} + {1'b0, b_op} + (WIDTH + 1)'(sub);

endmodule

>>> sim/gas_baseline_air_quality_classifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_baseline_air_quality_classifier_tb
// self-checking bench: scoreboard against a behavioral copy of the block
// ----------------------------------------------------------------------------
// every accepted s_ beat updates an in-bench copy of the tick counter, the
// seeded flag and the 24.16 ema baseline; each gas sample queues the reading
// it should produce. m_ beats are compared field by field with the oldest
// queued reading. directed tests cover register defaults, level thresholds,
// weight and warmup extremes and a long output stall; then random warmup
// sessions with random content, noise and broken sequences. both sides idle
// at random, with one calm stretch where neither side idles.
// ----------------------------------------------------------------------------
module gas_baseline_air_quality_classifier_tb
    import gbaq_pkg::*;
();

    // encodings the package leaves unnamed
    localparam logic [CMD_W-1:0]     CMD_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int     IDLE_PCT       = 7;      // idle chance per cycle / beat
    localparam int     HOLD_CYCLES    = 400;    // long receiver stall
    localparam int     SETTLE_CYCLES  = 48;     // pause that outlasts a sample in flight
    localparam int     DRAIN_LIMIT    = 20000;
    localparam int     RANDOM_BEATS   = 300;
    localparam longint RUN_LIMIT_NS   = 10_000_000;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    gbaq_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    gbaq_out_t m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // behavioral copy of the block state and its registers
    logic [15:0]      tick_count;
    bit               baseline_seeded;
    logic [39:0]      baseline_fx;
    logic [CFG_W-1:0] warmup_setting;
    logic [CFG_W-1:0] weight_setting;

    gbaq_out_t pending_readings[$];

    // shared flags between the stimulus and the result sink
    bit calm_stretch;
    bit hold_off_req;

    // run statistics
    int mismatch_count;
    int beats_sent;
    int samples_sent;
    int ready_samples;
    int ticks_sent;
    int restarts_sent;
    int spare_sent;
    int readings_checked;
    int level_hits [0:4];

    gas_baseline_air_quality_classifier DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // behavioral prediction
    // ------------------------------------------------------------------------

    // apply one accepted beat to the copy of the state; a gas sample queues
    // the reading the block has to answer with
    task automatic predict_air_quality(input gbaq_in_t beat);
        logic [39:0]        sample_fx;
        logic [39:0]        step_mag;
        logic [55:0]        scaled;
        logic [39:0]        quotient;
        logic [39:0]        divisor;
        bit                 rising;
        gbaq_out_t          want;
        case (beat.cmd)
            CMD_TICK: begin
                // counter saturates at all ones
                if (tick_count != 16'hFFFF) tick_count++;
                ticks_sent++;
            end
            CMD_RESTART: begin
                tick_count      = '0;
                baseline_seeded = 1'b0;
                baseline_fx     = '0;
                restarts_sent++;
            end
            CMD_SAMPLE: begin
                samples_sent++;
                sample_fx = {beat.gas_ohms, 16'h0000};
                // first sample past warmup seeds the baseline, then the
                // regular ema step still runs on it (a zero move)
                if (!baseline_seeded && tick_count >= warmup_setting) begin
                    baseline_fx     = sample_fx;
                    baseline_seeded = 1'b1;
                end
                if (!baseline_seeded) begin
                    want.ready_res     = 1'b0;
                    want.ratio_q412    = '0;
                    want.quality_level = LVL_WARMUP;
                end else begin
                    ready_samples++;
                    rising   = (sample_fx >= baseline_fx);
                    step_mag = rising ? sample_fx - baseline_fx : baseline_fx - sample_fx;
                    // step truncated toward the old baseline
                    scaled = step_mag * weight_setting;
                    baseline_fx = rising ? baseline_fx + scaled[55:16]
                                         : baseline_fx - scaled[55:16];
                    // q4.12 ratio: (baseline << 16) / (gas << 16) * 4096
                    if (beat.gas_ohms == '0) begin
                        want.ratio_q412 = RATIO_MAX;
                    end else begin
                        divisor  = {beat.gas_ohms, 4'h0};
                        quotient = baseline_fx / divisor;
                        want.ratio_q412 = (quotient > 40'(RATIO_MAX)) ? RATIO_MAX
                                                                      : quotient[15:0];
                    end
                    want.ready_res = 1'b1;
                    if (want.ratio_q412 < THR_CLEAN)         want.quality_level = LVL_CLEAN;
                    else if (want.ratio_q412 < THR_NORMAL)   want.quality_level = LVL_NORMAL;
                    else if (want.ratio_q412 < THR_POLLUTED) want.quality_level = LVL_POLLUTED;
                    else                                     want.quality_level = LVL_VPOLLUTED;
                end
                level_hits[want.quality_level]++;
                pending_readings.push_back(want);
            end
            default: begin
                // unused command leaves everything alone
                spare_sent++;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // offer one beat, hold it until taken, then feed it to the prediction
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [GAS_W-1:0] gas);
        gbaq_in_t beat;
        beat.cmd      = cmd;
        beat.gas_ohms = gas;
        if (!calm_stretch && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_air_quality(beat);
        beats_sent++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_beat(CMD_TICK, GAS_W'($urandom));
    endtask

    // registers change only with the block idle: all readings in, plus a
    // pause that covers a sample still in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_WARMUP: warmup_setting = value;
            REG_WEIGHT: weight_setting = value;
            default: ;
        endcase
    endtask

    function automatic logic [CFG_W-1:0] pick_weight();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 16'd1;
            3:       return 16'($urandom_range(100, 5000));
            default: return 16'($urandom);
        endcase
    endfunction

    // typical resistance of a session: small, room-air range, large, any
    function automatic logic [GAS_W-1:0] pick_base_ohms();
        case ($urandom_range(0, 9))
            0, 1:    return GAS_W'($urandom_range(1, 200));
            7, 8:    return GAS_W'($urandom_range(32'h0010_0000, 32'h00FF_FFFF));
            9:       return GAS_W'($urandom);
            default: return GAS_W'($urandom_range(1000, 500000));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset values: the long default warmup holds samples back, the default
    // weight drives the ema once a short warmup lets the baseline seed;
    // restart keeps the registers
    task automatic test_register_defaults;
        send_beat(CMD_SAMPLE, 24'd120000);
        send_beat(CMD_SPARE, 24'hFFFFFF);
        send_ticks(10);
        send_beat(CMD_SAMPLE, 24'd120000);        // deep in the default warmup
        write_reg(REG_WARMUP, 16'd14);
        send_ticks(3);
        send_beat(CMD_SAMPLE, 24'd120000);        // one second short
        send_ticks(1);
        send_beat(CMD_SAMPLE, 24'd120000);        // seeds the baseline
        send_beat(CMD_SAMPLE, 24'd0);             // zero sample
        send_beat(CMD_SAMPLE, 24'd1);             // ratio overflow
        send_beat(CMD_SAMPLE, 24'hFFFFFF);
        send_beat(CMD_SAMPLE, 24'd100000);
        send_beat(CMD_RESTART, 24'hFFFFFF);
        send_beat(CMD_SAMPLE, 24'd120000);        // warming up again
    endtask

    // with a frozen baseline of b ohms, a 4096 ohm sample gives ratio b
    task automatic test_threshold_edges;
        logic [GAS_W-1:0] edges [8];
        edges = '{24'd3685, 24'd3686, 24'd4505, 24'd4506,
                  24'd6143, 24'd6144, 24'd65535, 24'd65536};
        write_reg(REG_WARMUP, 16'd0);
        write_reg(REG_WEIGHT, 16'd0);
        foreach (edges[i]) begin
            send_beat(CMD_RESTART, '0);
            send_beat(CMD_SAMPLE, edges[i]);
            send_beat(CMD_SAMPLE, 24'd4096);
        end
    endtask

    // zero weight keeps the seed, full weight nearly jumps to the sample;
    // writes to unknown indexes must change nothing
    task automatic test_weight_extremes;
        send_beat(CMD_RESTART, '0);
        send_beat(CMD_SAMPLE, 24'd5000);
        send_beat(CMD_SAMPLE, 24'd2000);
        send_beat(CMD_SAMPLE, 24'd5500);
        write_reg(REG_WEIGHT, 16'hFFFF);
        send_beat(CMD_SAMPLE, 24'd9000000);
        send_beat(CMD_SAMPLE, 24'hFFFFFF);
        send_beat(CMD_SAMPLE, 24'd0);
        send_beat(CMD_SAMPLE, 24'd3);
        write_reg(REG_SPARE_A, 16'($urandom));
        write_reg(REG_SPARE_B, 16'($urandom));
        send_beat(CMD_SAMPLE, 24'd700000);
        write_reg(REG_WEIGHT, 16'd1);
        send_beat(CMD_SAMPLE, 24'd10);
        send_beat(CMD_SAMPLE, 24'hABCDEF);
    endtask

    // all-ones warmup stays out of reach, zero warmup seeds at once, and a
    // short warmup is walked up to its last second
    task automatic test_warmup_extremes;
        write_reg(REG_WARMUP, 16'hFFFF);
        write_reg(REG_WEIGHT, 16'd32768);
        send_beat(CMD_RESTART, '0);
        send_beat(CMD_SAMPLE, 24'd80000);
        send_ticks(40);
        send_beat(CMD_SAMPLE, 24'd80000);
        write_reg(REG_WARMUP, 16'd0);
        send_beat(CMD_SAMPLE, 24'd80000);         // seeds without a restart
        send_beat(CMD_SAMPLE, 24'd60000);
        send_beat(CMD_SPARE, 24'd1);
        send_beat(CMD_SAMPLE, 24'd95000);
        send_beat(CMD_RESTART, '0);
        send_beat(CMD_SAMPLE, 24'd95000);         // seeds right after restart
        write_reg(REG_WARMUP, 16'd3);
        send_beat(CMD_RESTART, '0);
        send_ticks(2);
        send_beat(CMD_SAMPLE, 24'd70000);         // one second short
        send_ticks(1);
        send_beat(CMD_SAMPLE, 24'd70000);
        send_beat(CMD_SAMPLE, 24'd50000);
    endtask

    // receiver stalls for a long stretch while samples keep coming, so the
    // output register fills and the next sample backs up into s_ready
    task automatic test_output_backpressure;
        write_reg(REG_WARMUP, 16'd0);
        write_reg(REG_WEIGHT, 16'd8000);
        send_beat(CMD_RESTART, '0);
        hold_off_req = 1'b1;
        repeat (12) begin
            send_beat(CMD_SAMPLE, GAS_W'($urandom_range(40000, 60000)));
            send_beat(CMD_TICK, '0);
        end
    endtask

    // warmup sessions: restart, ticks up to (mostly past) warmup, then
    // samples around a session resistance with noise mixed in
    task automatic test_random_sessions;
        int               start_count;
        int               pick;
        longint           scaled;
        logic [GAS_W-1:0] base_ohms;
        start_count = beats_sent;
        while (beats_sent - start_count < RANDOM_BEATS) begin
            calm_stretch = (beats_sent - start_count >= 150) &&
                           (beats_sent - start_count < 260);
            if ($urandom_range(0, 2) == 0) begin
                write_reg(REG_WEIGHT, pick_weight());
                write_reg(REG_WARMUP, 16'($urandom_range(0, 12)));
            end
            send_beat(CMD_RESTART, GAS_W'($urandom));
            // now and then stop short of warmup
            if ($urandom_range(0, 4) == 0)
                send_ticks($urandom_range(0, warmup_setting));
            else
                send_ticks(warmup_setting + $urandom_range(0, 3));
            base_ohms = pick_base_ohms();
            repeat ($urandom_range(4, 30)) begin
                pick = $urandom_range(0, 99);
                if (pick < 68) begin
                    scaled = longint'(base_ohms) * $urandom_range(4, 28) / 16;
                    if (scaled > 64'hFF_FFFF) scaled = 64'hFF_FFFF;
                    send_beat(CMD_SAMPLE, GAS_W'(scaled));
                end else if (pick < 76) begin
                    send_beat(CMD_SAMPLE, GAS_W'($urandom));
                end else if (pick < 80) begin
                    send_beat(CMD_SAMPLE, '0);
                end else if (pick < 85) begin
                    send_beat(CMD_SAMPLE, GAS_W'($urandom_range(1, 15)));
                end else if (pick < 92) begin
                    send_beat(CMD_TICK, GAS_W'($urandom));
                end else if (pick < 97) begin
                    send_beat(CMD_SPARE, GAS_W'($urandom));
                end else begin
                    send_beat(CMD_RESTART, GAS_W'($urandom));
                end
            end
        end
        calm_stretch = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    // m_ready: random idle cycles, a calm stretch, and one long hold-off
    initial begin : result_sink
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_ready <= calm_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // scoreboard: each taken reading against the oldest queued one
    always @(posedge aclk) begin : reading_check
        gbaq_out_t want;
        if (aresetn && m_valid && m_ready) begin
            readings_checked++;
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected reading, got ready %0b ratio %0d level %0d",
                         $time, m_data.ready_res, m_data.ratio_q412, m_data.quality_level);
                mismatch_count++;
            end else begin
                want = pending_readings.pop_front();
                if (m_data.ready_res !== want.ready_res) begin
                    $display("%0t: ready_res expected %0b, got %0b",
                             $time, want.ready_res, m_data.ready_res);
                    mismatch_count++;
                end
                if (m_data.ratio_q412 !== want.ratio_q412) begin
                    $display("%0t: ratio_q412 expected %0d, got %0d",
                             $time, want.ratio_q412, m_data.ratio_q412);
                    mismatch_count++;
                end
                if (m_data.quality_level !== want.quality_level) begin
                    $display("%0t: quality_level expected %0d, got %0d",
                             $time, want.quality_level, m_data.quality_level);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin : test_sequence
        int waited;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        tick_count      = '0;
        baseline_seeded = 1'b0;
        baseline_fx     = '0;
        warmup_setting  = WARMUP_RESET;
        weight_setting  = WEIGHT_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_defaults();
        test_threshold_edges();
        test_weight_extremes();
        test_warmup_extremes();
        test_output_backpressure();
        test_random_sessions();

        // drain, then a tail for anything the block still owes or invents
        s_valid <= 1'b0;
        waited = 0;
        while (pending_readings.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_readings.size() != 0) begin
            $display("%0t: %0d readings never arrived", $time, pending_readings.size());
            mismatch_count += pending_readings.size();
        end

        $display("covered %0d beats: %0d samples (%0d past warmup), %0d ticks,",
                 beats_sent, samples_sent, ready_samples, ticks_sent);
        $display("  %0d restarts, %0d unused; readings checked %0d",
                 restarts_sent, spare_sent, readings_checked);
        $display("levels warmup/1/2/3/4 %0d/%0d/%0d/%0d/%0d, mismatches %0d",
                 level_hits[0], level_hits[1], level_hits[2],
                 level_hits[3], level_hits[4], mismatch_count);
        if (mismatch_count == 0) begin
            $display("gas_baseline_air_quality_classifier_tb: PASS");
        end else begin
            $display("gas_baseline_air_quality_classifier_tb: FAIL");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("gas_baseline_air_quality_classifier_tb: FAIL");
        $finish;
    end

endmodule
